>>> rtl/tlfs_pkg.sv
// ----------------------------------------------------------------------------
// tlfs_pkg
// Shared types and constants of the three-level feedback scheduler.
// ----------------------------------------------------------------------------
package tlfs_pkg;

	localparam logic [7:0] PRIO_MAX = 8'd149;

	localparam logic [1:0] CMD_READY = 2'd0;
	localparam logic [1:0] CMD_PICK  = 2'd1;
	localparam logic [1:0] CMD_AGE   = 2'd2;

	// configuration register indexes
	localparam logic [1:0] REG_AGING_WAIT = 2'd0;
	localparam logic [1:0] REG_AGING_INC  = 2'd1;
	localparam logic [1:0] REG_TOP_FLOOR  = 2'd2;
	localparam logic [1:0] REG_MID_FLOOR  = 2'd3;

	// controller to datapath
	typedef struct packed {
		logic capture;  // latch the input item
		logic search;   // scan result registered
		logic execute;  // update table and build result
	} tlfs_ctrl_t;

endpackage

>>> rtl/tlfs_datapath.sv
// ----------------------------------------------------------------------------
// tlfs_datapath
// Ready table, slot search, pick compare, aging and preemption arithmetic.
// ----------------------------------------------------------------------------
module tlfs_datapath import tlfs_pkg::*; #(
	parameter int TABLE_SLOTS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  tlfs_ctrl_t  ctrl,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic [1:0]  cmd,
	input  logic [7:0]  task_id,
	input  logic [7:0]  task_priority,
	input  logic [15:0] task_burst,
	input  logic [31:0] now_ticks,
	input  logic [31:0] user_ticks,
	output logic        done,
	output logic        picked_valid,
	output logic [7:0]  picked_id,
	output logic [1:0]  picked_level,
	output logic        preempt,
	output logic        aged,
	output logic [7:0]  new_priority,
	output logic [1:0]  new_level,
	output logic        promoted_to_top,
	output logic        table_full
);
	localparam int SW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
	localparam int NP = 1 << SW;
	localparam int KW = 51;

	// configuration registers
	logic [15:0] aging_wait_q;
	logic [7:0]  aging_inc_q, top_floor_q, mid_floor_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			aging_wait_q <= 16'd1500;
			aging_inc_q  <= 8'd10;
			top_floor_q  <= 8'd100;
			mid_floor_q  <= 8'd50;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_AGING_WAIT: aging_wait_q <= cfg_data;
				REG_AGING_INC:  aging_inc_q  <= cfg_data[7:0];
				REG_TOP_FLOOR:  top_floor_q  <= cfg_data[7:0];
				REG_MID_FLOOR:  mid_floor_q  <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// table
	logic [TABLE_SLOTS-1:0] used_q;
	logic [7:0]  task_q  [TABLE_SLOTS];
	logic [7:0]  prio_q  [TABLE_SLOTS];
	logic [15:0] burst_q [TABLE_SLOTS];
	logic [31:0] wait_q  [TABLE_SLOTS];
	logic [1:0]  level_q [TABLE_SLOTS];
	logic [31:0] order_q [TABLE_SLOTS];
	logic [31:0] order_cnt_q;
	logic        run_valid_q;
	logic [7:0]  run_task_q, run_prio_q;
	logic [15:0] run_burst_q;
	logic [31:0] run_start_q;

	// captured item
	logic [1:0]  cmd_q;
	logic [7:0]  id_q, pri_q;
	logic [15:0] burst_in_q;
	logic [31:0] now_q, user_q;

	function automatic logic [1:0] level_for(input logic [7:0] p, input logic [7:0] tf,
			input logic [7:0] mf);
		if (p >= tf && p <= PRIO_MAX) return 2'd1;
		if (p >= mf && p <= PRIO_MAX) return 2'd2;
		return 2'd3;
	endfunction

	// task lookup and first free slot (priority encoders)
	logic          hit, free_ok, best_ok;
	logic [SW-1:0] hit_idx, free_idx, best_idx;
	always_comb begin
		hit = 1'b0; hit_idx = '0; free_ok = 1'b0; free_idx = '0;
		for (int i = 0; i < TABLE_SLOTS; i++) begin
			if (used_q[i] && task_q[i] == id_q && !hit) begin
				hit = 1'b1; hit_idx = SW'(i);
			end
			if (!used_q[i] && !free_ok) begin
				free_ok = 1'b1; free_idx = SW'(i);
			end
		end
	end

	// best pick: per-slot sort key, then a compare tree (lowest key wins,
	// lower slot wins a tie). Key: free flag, level, level rule, inverted age.
	always_comb begin
		logic [KW-1:0] key [NP];
		logic [SW-1:0] idx [NP];
		logic [31:0]   age;
		logic [15:0]   sec;
		for (int i = 0; i < NP; i++) begin
			key[i] = '1;
			idx[i] = SW'(i);
		end
		for (int i = 0; i < TABLE_SLOTS; i++) begin
			age = order_cnt_q - order_q[i];
			if (level_q[i] == 2'd1) sec = burst_q[i];
			else if (level_q[i] == 2'd2) sec = {8'd0, ~prio_q[i]};
			else sec = 16'd0;
			if (used_q[i]) key[i] = {1'b0, level_q[i], sec, ~age};
		end
		for (int w = NP >> 1; w >= 1; w = w >> 1) begin
			for (int j = 0; j < w; j++) begin
				if (key[2*j+1] < key[2*j]) begin
					key[j] = key[2*j+1]; idx[j] = idx[2*j+1];
				end else begin
					key[j] = key[2*j]; idx[j] = idx[2*j];
				end
			end
		end
		best_ok  = !key[0][KW-1];
		best_idx = idx[0];
	end

	// registered search results
	logic          hit_s1, free_ok_s1, best_ok_s1;
	logic [SW-1:0] hit_idx_s1, free_idx_s1, best_idx_s1;
	always_ff @(posedge clk) begin
		if (ctrl.search) begin
			hit_s1 <= hit; hit_idx_s1 <= hit_idx;
			free_ok_s1 <= free_ok; free_idx_s1 <= free_idx;
			best_ok_s1 <= best_ok; best_idx_s1 <= best_idx;
		end
	end

	// execute-phase arithmetic
	logic [7:0]  pri_sat, np, cur_p;
	logic [8:0]  np_sum;
	logic [1:0]  ins_lvl, tgt, cur_l;
	logic [31:0] waited;
	logic        fire;
	logic [15:0] pre_burst;
	logic [7:0]  pre_id;
	logic        pre_en, pre_ok;
	logic [16:0] lhs;
	logic [32:0] rhs;
	always_comb begin
		pri_sat = (pri_q > PRIO_MAX) ? PRIO_MAX : pri_q;
		ins_lvl = level_for(pri_sat, top_floor_q, mid_floor_q);
		cur_p   = prio_q[hit_idx_s1];
		cur_l   = level_q[hit_idx_s1];
		waited  = now_q - wait_q[hit_idx_s1];
		fire    = hit_s1 && (waited >= {16'd0, aging_wait_q});
		np_sum  = {1'b0, cur_p} + {1'b0, aging_inc_q};
		np      = (np_sum > {1'b0, PRIO_MAX}) ? PRIO_MAX : np_sum[7:0];
		tgt     = level_for(np, top_floor_q, mid_floor_q);
		if (cmd_q == CMD_READY) begin
			pre_en = (hit_s1 || free_ok_s1) && ins_lvl == 2'd1;
			pre_burst = burst_in_q;
		end else begin
			pre_en = fire && tgt < cur_l && tgt == 2'd1;
			pre_burst = burst_q[hit_idx_s1];
		end
		pre_id = id_q;
		lhs = {pre_burst, 1'b0};
		rhs = {1'b0, user_q - run_start_q} + {17'd0, run_burst_q};
		pre_ok = run_valid_q && run_prio_q >= top_floor_q && run_prio_q <= PRIO_MAX
			&& run_task_q != pre_id && ({16'd0, lhs} < rhs);
	end

	logic [SW-1:0] ins_idx;
	assign ins_idx = hit_s1 ? hit_idx_s1 : free_idx_s1;

	// next result fields
	logic       nx_pvalid, nx_preempt, nx_aged, nx_promo, nx_full;
	logic [7:0] nx_pid, nx_npri;
	logic [1:0] nx_plevel, nx_nlevel;
	always_comb begin
		nx_pvalid = 1'b0; nx_pid = '0; nx_plevel = '0; nx_preempt = 1'b0;
		nx_aged = 1'b0; nx_npri = '0; nx_nlevel = '0; nx_promo = 1'b0; nx_full = 1'b0;
		case (cmd_q)
			CMD_READY: begin
				if (hit_s1 || free_ok_s1) nx_preempt = pre_en && pre_ok;
				else nx_full = 1'b1;
			end
			CMD_PICK: if (best_ok_s1) begin
				nx_pvalid = 1'b1;
				nx_pid    = task_q[best_idx_s1];
				nx_plevel = level_q[best_idx_s1];
			end
			CMD_AGE: if (hit_s1) begin
				if (fire) begin
					nx_aged = 1'b1;
					nx_npri = np;
					if (tgt < cur_l) begin
						nx_nlevel  = tgt;
						nx_promo   = tgt == 2'd1;
						nx_preempt = pre_en && pre_ok;
					end else nx_nlevel = cur_l;
				end else begin
					nx_npri   = cur_p;
					nx_nlevel = cur_l;
				end
			end
			default: ;
		endcase
	end

	// control state of the table
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0; order_cnt_q <= '0; run_valid_q <= 1'b0;
			run_task_q <= '0; run_prio_q <= '0; run_burst_q <= '0; run_start_q <= '0;
			done <= 1'b0;
		end else begin
			done <= ctrl.execute;
			if (ctrl.execute) begin
				case (cmd_q)
					CMD_READY: if (hit_s1 || free_ok_s1) begin
						used_q[ins_idx] <= 1'b1;
						order_cnt_q <= order_cnt_q + 32'd1;
					end
					CMD_PICK: if (best_ok_s1) begin
						used_q[best_idx_s1] <= 1'b0;
						run_valid_q <= 1'b1;
						run_task_q  <= task_q[best_idx_s1];
						run_prio_q  <= prio_q[best_idx_s1];
						run_burst_q <= burst_q[best_idx_s1];
						run_start_q <= user_q;
					end
					CMD_AGE: if (fire && tgt < cur_l) order_cnt_q <= order_cnt_q + 32'd1;
					default: ;
				endcase
			end
		end
	end

	// item capture, slot payload and result registers
	always_ff @(posedge clk) begin
		if (ctrl.capture) begin
			cmd_q <= cmd; id_q <= task_id; pri_q <= task_priority;
			burst_in_q <= task_burst; now_q <= now_ticks; user_q <= user_ticks;
		end
		if (ctrl.execute) begin
			picked_valid <= nx_pvalid; picked_id <= nx_pid; picked_level <= nx_plevel;
			preempt <= nx_preempt; aged <= nx_aged; new_priority <= nx_npri;
			new_level <= nx_nlevel; promoted_to_top <= nx_promo; table_full <= nx_full;
			case (cmd_q)
				CMD_READY: if (hit_s1 || free_ok_s1) begin
					task_q[ins_idx]  <= id_q;
					prio_q[ins_idx]  <= pri_sat;
					burst_q[ins_idx] <= burst_in_q;
					wait_q[ins_idx]  <= now_q;
					level_q[ins_idx] <= ins_lvl;
					order_q[ins_idx] <= order_cnt_q;
				end
				CMD_AGE: if (fire) begin
					prio_q[hit_idx_s1] <= np;
					wait_q[hit_idx_s1] <= now_q;
					if (tgt < cur_l) begin
						level_q[hit_idx_s1] <= tgt;
						order_q[hit_idx_s1] <= order_cnt_q;
					end
				end
				default: ;
			endcase
		end
	end

	ap_pick_level: assert property (@(posedge clk) disable iff (!arst_n)
		done && picked_valid |-> picked_level != 2'd0) else $error("pick level zero");
	ap_full_alone: assert property (@(posedge clk) disable iff (!arst_n)
		done && table_full |-> !picked_valid && !aged) else $error("full mixed");
	ap_promote: assert property (@(posedge clk) disable iff (!arst_n)
		done && promoted_to_top |-> aged && new_level == 2'd1) else $error("bad promote");
endmodule

>>> rtl/tlfs_ctrl.sv
// ----------------------------------------------------------------------------
// tlfs_ctrl
// Sequencer: capture item, register slot search, execute update.
// ----------------------------------------------------------------------------
module tlfs_ctrl import tlfs_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	output tlfs_ctrl_t ctrl
);
	typedef enum logic [1:0] {ST_IDLE, ST_SEARCH, ST_EXEC, ST_DONE} state_t;
	state_t state_q;

	always_comb begin
		ctrl.capture = (state_q == ST_IDLE) && start;
		ctrl.search  = state_q == ST_SEARCH;
		ctrl.execute = state_q == ST_EXEC;
		busy = state_q != ST_IDLE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else begin
			case (state_q)
				ST_IDLE:   if (start) state_q <= ST_SEARCH;
				ST_SEARCH: state_q <= ST_EXEC;
				ST_EXEC:   state_q <= ST_DONE;
				ST_DONE:   state_q <= ST_IDLE;
				default:   state_q <= ST_IDLE;
			endcase
		end
	end

	ap_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.capture |=> busy) else $error("no busy after capture");
endmodule

>>> rtl/three_level_feedback_scheduler_unit.sv
// ----------------------------------------------------------------------------
// three_level_feedback_scheduler_unit
// Flow: the accepting edge captures the item, then the registered slot scan (search)
// and the table update (execute) follow, and done goes high; a new start is taken
// only back in idle, so the unit does not accept an item while one is in flight.
// Results show for one cycle on done; the receiver cannot stall.
// Reset empties the table, clears the running task and loads register defaults.
// ----------------------------------------------------------------------------
module three_level_feedback_scheduler_unit import tlfs_pkg::*; #(
	parameter int TABLE_SLOTS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	output logic        done,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic [1:0]  cmd,
	input  logic [7:0]  task_id,
	input  logic [7:0]  task_priority,
	input  logic [15:0] task_burst,
	input  logic [31:0] now_ticks,
	input  logic [31:0] user_ticks,
	output logic        picked_valid,
	output logic [7:0]  picked_id,
	output logic [1:0]  picked_level,
	output logic        preempt,
	output logic        aged,
	output logic [7:0]  new_priority,
	output logic [1:0]  new_level,
	output logic        promoted_to_top,
	output logic        table_full
);
	tlfs_ctrl_t ctrl;

	tlfs_ctrl u_ctrl (.clk, .arst_n, .start, .busy, .ctrl);

	tlfs_datapath #(.TABLE_SLOTS(TABLE_SLOTS)) u_dp (
		.clk, .arst_n, .ctrl, .cfg_we, .cfg_index, .cfg_data, .cmd, .task_id,
		.task_priority, .task_burst, .now_ticks, .user_ticks, .done,
		.picked_valid, .picked_id, .picked_level, .preempt, .aged,
		.new_priority, .new_level, .promoted_to_top, .table_full
	);
endmodule
